### sv/bvag_pkg.sv
package bvag_pkg;

    // Field widths
    localparam int CODE_W   = 12;
    localparam int SUM_W    = 16;
    localparam int VOLT_W   = 9;
    localparam int PCT_W    = 9;
    localparam int TENTHS_W = 7;

    // Stream word widths, padded to whole bytes
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Voltage scaling: tenths = round(sum * 99 / (4096 * window))
    localparam int VOLT_SCALE = 99;
    localparam int ADC_SHIFT  = 12;
    localparam int X_W        = 24;

    // Top clamp
    localparam logic [TENTHS_W-1:0] TENTHS_CLAMP = 7'd42;
    localparam logic [VOLT_W-1:0]   VOLT_CLAMP   = 9'd419;
    localparam logic [PCT_W-1:0]    PCT_FULL     = 9'd100;

    // Charge line: trunc((tenths - 28) * 1000 / 139)
    // 1000 / 139 is folded into one reciprocal multiply, 1000 * ceil(2^23 / 139)
    localparam logic [TENTHS_W-1:0] TENTHS_EMPTY = 7'd28;
    localparam int                  MAG_W        = 5;
    localparam int                  CHARGE_SHIFT = 23;
    localparam int                  CHARGE_MUL_W = 26;
    localparam logic [CHARGE_MUL_W-1:0] CHARGE_MUL = 26'd60350000;
    localparam int                  CHARGE_P_W   = MAG_W + CHARGE_MUL_W;

    // Running-sum stage hands its word to the scaling pipeline
    typedef struct packed {
        logic             vld;
        logic [SUM_W-1:0] sum;
    } ring_out_t;

endpackage

### sv/bvag_ring.sv
module bvag_ring
    import bvag_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CODE_W-1:0] in_code,
    output ring_out_t         ring_o,
    input  logic              out_take
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    // Sample ring, synchronous read
    logic [CODE_W-1:0] ring_mem [WINDOW];
    logic [CODE_W-1:0] rd_data_reg;
    logic [WINDOW-1:0] entry_vld_reg;

    logic [SLOT_W-1:0] write_slot_reg;
    logic [SUM_W-1:0]  window_sum_reg;

    // Read stage
    logic              a_valid_reg;
    logic [CODE_W-1:0] a_code_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    logic              a_live_reg;
    logic              a_fwd_reg;
    logic [CODE_W-1:0] a_fwd_code_reg;

    // Sum stage
    logic              b_valid_reg;
    logic [SUM_W-1:0]  b_sum_reg;

    logic              b_free;
    logic              a_adv;
    logic              accept;
    logic [CODE_W-1:0] old_code;
    logic [SUM_W-1:0]  window_sum_next;
    logic [SLOT_W-1:0] write_slot_next;

    assign b_free   = !b_valid_reg || out_take;
    assign a_adv    = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || b_free;
    assign accept   = in_valid && in_ready;

    // Pick the evicted code: forwarded write, stored entry, or zero if never written
    always_comb begin
        if (a_fwd_reg) begin
            old_code = a_fwd_code_reg;
        end else if (a_live_reg) begin
            old_code = rd_data_reg;
        end else begin
            old_code = '0;
        end
        window_sum_next = window_sum_reg - SUM_W'(old_code) + SUM_W'(a_code_reg);
        write_slot_next = (write_slot_reg == LAST_SLOT) ? '0 : write_slot_reg + 1'b1;
    end

    // Read the slot to be replaced
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= ring_mem[write_slot_reg];
        end
    end

    // Write back the new code
    always_ff @(posedge aclk) begin
        if (a_adv) begin
            ring_mem[a_slot_reg] <= a_code_reg;
        end
    end

    // Control and running sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_vld_reg  <= '0;
            write_slot_reg <= '0;
            window_sum_reg <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                write_slot_reg <= write_slot_next;
                a_valid_reg    <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                entry_vld_reg[a_slot_reg] <= 1'b1;
                window_sum_reg            <= window_sum_next;
                b_valid_reg               <= 1'b1;
            end else if (out_take) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the read and sum stages
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_code_reg     <= in_code;
            a_slot_reg     <= write_slot_reg;
            a_live_reg     <= entry_vld_reg[write_slot_reg];
            a_fwd_reg      <= a_adv && (a_slot_reg == write_slot_reg);
            a_fwd_code_reg <= a_code_reg;
        end
        if (a_adv) begin
            b_sum_reg <= window_sum_next;
        end
    end

    assign ring_o.vld = b_valid_reg;
    assign ring_o.sum = b_sum_reg;

endmodule

### sv/bvag_scale.sv
module bvag_scale
    import bvag_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ring_out_t           ring_i,
    output logic                ring_take,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VOLT_W-1:0]   out_volt,
    output logic signed [PCT_W-1:0] out_pct
);

    // Rounding bias and reciprocal of the window length
    localparam int BIAS     = 2048 * WINDOW;
    localparam int Q_W      = $clog2(100 * WINDOW + 1);
    localparam int R_SHIFT  = Q_W + $clog2(WINDOW) + 1;
    localparam int R_W      = R_SHIFT + 1;
    localparam logic [R_W-1:0] RECIP = R_W'(((1 << R_SHIFT) + WINDOW - 1) / WINDOW);

    logic              c_valid_reg;
    logic [X_W-1:0]    c_x_reg;
    logic              d_valid_reg;
    logic [TENTHS_W-1:0] d_tenths_reg;
    logic              m_valid_reg;
    logic [VOLT_W-1:0] m_volt_reg;
    logic [PCT_W-1:0]  m_pct_reg;

    logic              m_free;
    logic              d_free;
    logic              c_free;
    logic [Q_W-1:0]    q;
    logic [Q_W+R_W-1:0] q_prod;
    logic [MAG_W-1:0]  mag;
    logic              below;
    logic [CHARGE_P_W-1:0] pct_prod;
    logic [PCT_W-1:0]  pct_mag;
    logic [VOLT_W-1:0] volt_next;
    logic [PCT_W-1:0]  pct_next;

    assign m_free    = !m_valid_reg || out_ready;
    assign d_free    = !d_valid_reg || m_free;
    assign c_free    = !c_valid_reg || d_free;
    assign ring_take = c_free;

    // Divide by the window through its reciprocal
    assign q      = c_x_reg[ADC_SHIFT +: Q_W];
    assign q_prod = (Q_W+R_W)'(q) * (Q_W+R_W)'(RECIP);

    // Charge from tenths, truncated toward zero
    always_comb begin
        below = d_tenths_reg < TENTHS_EMPTY;
        if (below) begin
            mag = MAG_W'(TENTHS_EMPTY - d_tenths_reg);
        end else begin
            mag = MAG_W'(d_tenths_reg - TENTHS_EMPTY);
        end
        pct_prod = CHARGE_P_W'(mag) * CHARGE_P_W'(CHARGE_MUL);
        pct_mag  = pct_prod[CHARGE_SHIFT +: PCT_W];
        if (d_tenths_reg >= TENTHS_CLAMP) begin
            volt_next = VOLT_CLAMP;
            pct_next  = PCT_FULL;
        end else begin
            volt_next = (VOLT_W'(d_tenths_reg) << 3) + (VOLT_W'(d_tenths_reg) << 1);
            pct_next  = below ? (~pct_mag + 1'b1) : pct_mag;
        end
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (c_free) begin
                c_valid_reg <= ring_i.vld;
            end
            if (d_free) begin
                d_valid_reg <= c_valid_reg;
            end
            if (m_free) begin
                m_valid_reg <= d_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (c_free && ring_i.vld) begin
            c_x_reg <= X_W'(ring_i.sum) * X_W'(VOLT_SCALE) + X_W'(BIAS);
        end
        if (d_free && c_valid_reg) begin
            d_tenths_reg <= q_prod[R_SHIFT +: TENTHS_W];
        end
        if (m_free && d_valid_reg) begin
            m_volt_reg <= volt_next;
            m_pct_reg  <= pct_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_volt  = m_volt_reg;
    assign out_pct   = $signed(m_pct_reg);

endmodule

### sv/battery_voltage_average_gauge.sv
// Boxcar-averaged battery gauge. Each 12-bit ADC word replaces the oldest of the
// last WINDOW samples in a ring memory, and a running sum of the ring gives the
// average voltage in tenths (half rounded up), reported in hundredths with a
// clamp at 4.19 V, along with a linear charge percent (2.8 V is 0, clamp is 100,
// negative below 2.8 V). The ring counts as all zeros after reset. One word is
// accepted per clock unless the output stalls; the ring memory's read of the
// evicted sample and its write-back overlap across consecutive words, with
// forwarding when they hit the same entry. A result passes through five pipeline
// registers (read, sum, scale, divide, output) on its way to the output, and
// stalls on the output side back up through those stages.
module battery_voltage_average_gauge
    import bvag_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [11:0] adc_code
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [8:0] voltage_hundredths, [17:9] charge_percent
);

    ring_out_t                   ring_w;
    logic                        ring_take;
    logic [VOLT_W-1:0]           volt;
    logic signed [PCT_W-1:0]     pct;

    bvag_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_code  (s_tdata[CODE_W-1:0]),
        .ring_o   (ring_w),
        .out_take (ring_take)
    );

    bvag_scale #(
        .WINDOW (WINDOW)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ring_i    (ring_w),
        .ring_take (ring_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_volt  (volt),
        .out_pct   (pct)
    );

    // Pack the result word
    assign m_tdata = {(M_DATA_W - VOLT_W - PCT_W)'(0), pct, volt};

endmodule
